### hw/rtl/mips_tlb_address_translate_macros.svh
// Assertion macros shared by the TLB translation block.
`ifndef MIPS_TLB_ADDRESS_TRANSLATE_MACROS_SVH
`define MIPS_TLB_ADDRESS_TRANSLATE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define MTLB_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define MTLB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the following cycle.
`define MTLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mtlb_pkg.sv
// Types, codes and constants of the TLB translation block.
package mtlb_pkg;

  localparam int TLB_ENTRIES_DEF = 64;
  localparam int IDX_FIELD_W     = 6;
  localparam int CFG_DATA_W      = 8;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RUN_ASID    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LEVEL = 1'd1;

  localparam logic CMD_WRITE = 1'b1;

  localparam logic [31:0] PAGE_MIN_SPAN = 32'h0000_1FFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REFILL   = 2'd1,
    ST_INVALID  = 2'd2,
    ST_MODIFIED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic                   cmd;
    logic [31:0]            vaddr;
    logic                   is_store;
    logic [IDX_FIELD_W-1:0] entry_index;
    logic [31:0]            page_mask;
    logic [31:0]            entry_hi;
    logic [31:0]            entry_lo_even;
    logic [31:0]            entry_lo_odd;
  } in_item_t;

  typedef struct packed {
    logic [31:0] paddr;
    status_t     status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] hi;
    logic [31:0] lo_even;
    logic [31:0] lo_odd;
  } tlb_entry_t;

endpackage

### hw/rtl/mtlb_mem.sv
// TLB entry store: one write port, one registered read port, per-entry valid bits.
module mtlb_mem import mtlb_pkg::*; #(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int IDX_W       = $clog2(TLB_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  tlb_entry_t       wr_entry,
  input  logic [IDX_W-1:0] rd_addr,
  output tlb_entry_t       rd_entry,
  output logic             rd_valid
);

  tlb_entry_t             mem [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

  // Entries never written read as all zero through the valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

### hw/rtl/mtlb_ctrl.sv
// Sequencer: decodes items, scans the entry store and holds the result register.
module mtlb_ctrl import mtlb_pkg::*; #(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int IDX_W       = $clog2(TLB_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic [7:0]       run_asid,
  input  logic             error_level,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output tlb_entry_t       wr_entry,
  output logic [IDX_W-1:0] rd_addr,
  input  tlb_entry_t       rd_entry,
  input  logic             rd_valid
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);
  localparam logic [8:0]       DEPTH_W9 = 9'(TLB_ENTRIES);

  ctrl_state_t      state, state_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [31:0]      va, va_next;
  logic             store, store_next;
  out_item_t        res, res_next;
  logic             load_out;

  logic [8:0]  idx_wide;
  tlb_entry_t  e;
  logic [31:0] span, cmp, sel, offmask, lo, pa;
  logic        hit, match;
  out_item_t   match_res;

  assign idx_wide = {{(9 - IDX_FIELD_W){1'b0}}, in_item.entry_index};
  assign wr_addr  = idx_wide[IDX_W-1:0];
  assign wr_entry = '{mask:    in_item.page_mask,
                      hi:      in_item.entry_hi,
                      lo_even: in_item.entry_lo_even,
                      lo_odd:  in_item.entry_lo_odd};

  // Evaluate the entry read for the current scan position.
  always_comb begin
    e       = rd_valid ? rd_entry : '0;
    span    = e.mask | PAGE_MIN_SPAN;
    cmp     = ~span;
    hit     = ((va ^ e.hi) & cmp) == 32'd0;
    match   = hit && ((e.lo_even[0] && e.lo_odd[0]) || (e.hi[7:0] == run_asid));
    sel     = (span + 32'd1) >> 1;
    lo      = ((va & sel) != 32'd0) ? e.lo_odd : e.lo_even;
    offmask = sel - 32'd1;
    pa      = ({lo[25:6], 12'd0} & ~offmask) | (va & offmask);
    if (!lo[1]) begin
      match_res = '{paddr: 32'd0, status: ST_INVALID};
    end else if (store && !lo[2]) begin
      match_res = '{paddr: 32'd0, status: ST_MODIFIED};
    end else begin
      match_res = '{paddr: pa, status: ST_OK};
    end
  end

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    va_next    = va;
    store_next = store;
    res_next   = res;
    in_ready   = 1'b0;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    rd_addr    = ptr + IDX_W'(1);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = '0;
        if (in_valid) begin
          va_next    = in_item.vaddr;
          store_next = in_item.is_store;
          state_next = S_FINISH;
          if (in_item.cmd == CMD_WRITE) begin
            wr_en    = idx_wide < DEPTH_W9;
            res_next = '{paddr: 32'd0, status: ST_OK};
          end else if (in_item.vaddr[31:30] == 2'b10) begin
            res_next = '{paddr: {3'd0, in_item.vaddr[28:0]}, status: ST_OK};
          end else if (error_level && !in_item.vaddr[31]) begin
            res_next = '{paddr: in_item.vaddr, status: ST_OK};
          end else begin
            ptr_next   = '0;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          res_next   = match_res;
          state_next = S_FINISH;
        end else if (ptr == LAST_IDX) begin
          res_next   = '{paddr: 32'd0, status: ST_REFILL};
          state_next = S_FINISH;
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr   <= ptr_next;
    va    <= va_next;
    store <= store_next;
    res   <= res_next;
    if (load_out) begin
      out_item <= res;
    end
  end

endmodule

### hw/rtl/mips_tlb_address_translate.sv
// Top level of the MIPS32 TLB address translation block.
//
// Usage:
// - in_valid/in_ready/in_item carry one command per transfer: translate a
//   virtual address (cmd 0) or load one TLB slot (cmd 1).
// - out_valid/out_ready/out_item return exactly one result per command:
//   a physical address and a status (ok, refill, invalid, modified).
// - cfg_we/cfg_index/cfg_data write run_asid (index 0) and error_level
//   (index 1); write only while no command is in flight.
// Path from accept to result valid: a slot write, a kseg0/kseg1 address or
// an unmapped kuseg address goes straight to the finish state; a lookup scans
// from slot 0 to the hit, or all TLB_ENTRIES slots for a refill. One command is
// in flight at a time, so the next one is taken the cycle the result is posted.
// The lookup walks the single-read-port entry store one slot a cycle and stops
// at the first hit; that walk sets the throughput.
// Reset: all slots read as zero (per-slot valid bits clear at once, no sweep),
// run_asid goes to 0 and error_level to 1.
// Receiver stall: the result holds in the output register; a finished lookup
// waits in its last state until the register frees.
module mips_tlb_address_translate import mtlb_pkg::*; #(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "mips_tlb_address_translate_macros.svh"

  localparam int IDX_W = $clog2(TLB_ENTRIES);

  logic [7:0]       run_asid;
  logic             error_level;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  tlb_entry_t       wr_entry;
  tlb_entry_t       rd_entry;
  logic             rd_valid;

  // Configuration registers: latch on write enable, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_asid    <= 8'd0;
      error_level <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RUN_ASID:    run_asid    <= cfg_data[7:0];
        CFG_ERROR_LEVEL: error_level <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  mtlb_mem #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  mtlb_ctrl #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .run_asid    (run_asid),
    .error_level (error_level),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_entry    (wr_entry),
    .rd_addr     (rd_addr),
    .rd_entry    (rd_entry),
    .rd_valid    (rd_valid)
  );

  // A failed translation never carries an address.
  `MTLB_ASSERT_SAME(a_err_paddr_zero, out_valid && (out_item.status != ST_OK), out_item.paddr == 32'd0, "error result with nonzero paddr")

  // One command in flight: an accept closes the input for the next cycle.
  `MTLB_ASSERT_NEXT(a_single_flight, in_valid && in_ready, !in_ready, "input open right after a transfer")

  // The store is written only while a command is being taken.
  `MTLB_ASSERT_SAME(a_write_on_accept, wr_en, in_valid && in_ready && (in_item.cmd == CMD_WRITE), "slot written outside a write transfer")

endmodule

### verif/mips_tlb_translate_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the TLB translation block: predicts each result and checks it on transfer.
module mips_tlb_translate_checker import mtlb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding,
  output int                    n_writes,
  output int                    n_ok,
  output int                    n_refill,
  output int                    n_invalid,
  output int                    n_modified
);

  localparam int          LO_GLOBAL   = 0;
  localparam int          LO_VALID    = 1;
  localparam int          LO_DIRTY    = 2;
  localparam logic [31:0] KSEG0_BASE  = 32'h8000_0000;
  localparam logic [31:0] KSEG1_TOP   = 32'hBFFF_FFFF;
  localparam logic [31:0] UNMAPPED_PA = 32'h1FFF_FFFF;

  tlb_entry_t slot [TLB_ENTRIES_DEF];
  logic [7:0] asid;
  logic       erl;
  out_item_t  pending_xlat [$];
  int         err_cnt, wr_cnt, ok_cnt, refill_cnt, inval_cnt, mod_cnt;

  initial begin
    err_cnt = 0; wr_cnt = 0; ok_cnt = 0; refill_cnt = 0; inval_cnt = 0; mod_cnt = 0;
  end

  // First matching slot in index order wins; global needs both G bits.
  function automatic out_item_t translate_va(input logic [31:0] va, input logic st);
    out_item_t  res;
    tlb_entry_t e;
    logic [31:0] span, cmp, sel, lo, offmask;
    logic        found;
    res.paddr  = '0;
    res.status = ST_REFILL;
    found      = 1'b0;
    if (va >= KSEG0_BASE && va <= KSEG1_TOP) begin
      res.paddr  = va & UNMAPPED_PA;
      res.status = ST_OK;
    end else if (erl && va < KSEG0_BASE) begin
      res.paddr  = va;
      res.status = ST_OK;
    end else begin
      for (int i = 0; i < TLB_ENTRIES_DEF; i++) begin
        e    = slot[i];
        span = e.mask | PAGE_MIN_SPAN;
        cmp  = ~span;
        if (!found && (va & cmp) == (e.hi & cmp) &&
            ((e.lo_even[LO_GLOBAL] && e.lo_odd[LO_GLOBAL]) || e.hi[7:0] == asid)) begin
          found   = 1'b1;
          sel     = (span + 32'd1) >> 1;
          lo      = ((va & sel) != 32'd0) ? e.lo_odd : e.lo_even;
          offmask = sel - 32'd1;
          if (!lo[LO_VALID]) begin
            res.status = ST_INVALID;
          end else if (st && !lo[LO_DIRTY]) begin
            res.status = ST_MODIFIED;
          end else begin
            res.status = ST_OK;
            res.paddr  = ((({8'd0, lo[29:6]}) << 12) & ~offmask) | (va & offmask);
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want, got;
    if (rst) begin
      for (int i = 0; i < TLB_ENTRIES_DEF; i++) slot[i] = '0;
      asid = 8'd0;
      erl  = 1'b1;
      pending_xlat.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_RUN_ASID) asid = cfg_data[7:0];
        else if (cfg_index == CFG_ERROR_LEVEL) erl = cfg_data[0];
      end
      // Predict on the input transfer; a slot write returns zero and ok.
      if (in_valid && in_ready) begin
        if (in_item.cmd == CMD_WRITE) begin
          want.paddr  = '0;
          want.status = ST_OK;
          if (in_item.entry_index < TLB_ENTRIES_DEF)
            slot[in_item.entry_index] = '{mask: in_item.page_mask, hi: in_item.entry_hi,
                                          lo_even: in_item.entry_lo_even,
                                          lo_odd: in_item.entry_lo_odd};
          wr_cnt++;
        end else begin
          want = translate_va(in_item.vaddr, in_item.is_store);
          case (want.status)
            ST_OK:       ok_cnt++;
            ST_REFILL:   refill_cnt++;
            ST_INVALID:  inval_cnt++;
            default:     mod_cnt++;
          endcase
        end
        pending_xlat.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_xlat.size() == 0) begin
          $error("result transfer with nothing expected: paddr %h status %0d",
                 out_item.paddr, out_item.status);
          err_cnt++;
        end else begin
          got = pending_xlat.pop_front();
          if (out_item.paddr !== got.paddr) begin
            $error("paddr mismatch: expected %h actual %h", got.paddr, out_item.paddr);
            err_cnt++;
          end
          if (out_item.status !== got.status) begin
            $error("status mismatch: expected %0d actual %0d", got.status, out_item.status);
            err_cnt++;
          end
        end
      end
    end
    errors      <= err_cnt;
    outstanding <= pending_xlat.size();
    n_writes    <= wr_cnt;
    n_ok        <= ok_cnt;
    n_refill    <= refill_cnt;
    n_invalid   <= inval_cnt;
    n_modified  <= mod_cnt;
  end

endmodule

### verif/mips_tlb_address_translate_tb.sv
`timescale 1ns / 100ps
// Testbench top for the TLB translation block: stimulus, receiver stalls and verdict.
module mips_tlb_address_translate_tb;
  import mtlb_pkg::*;

  localparam int          CLK_HALF     = 10;
  localparam int          RST_CYCLES   = 8;
  localparam int          RANDOM_ITEMS = 1150;
  localparam int          N_PHASES     = 6;
  // A refill walks every slot; leave room for one more walk after the last result.
  localparam int          DRAIN_CYCLES = TLB_ENTRIES_DEF + 8;
  localparam int          TIMEOUT_NS   = 20_000_000;
  localparam logic        CMD_XLAT     = ~CMD_WRITE;
  localparam logic [31:0] KSEG0_BASE   = 32'h8000_0000;
  localparam logic [31:0] KSEG01_SPAN  = 32'h3FFF_FFFF;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RUN_ASID;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int errors, outstanding, n_writes, n_ok, n_refill, n_invalid, n_modified;

  // Stimulus-side copy of what was loaded, used only to aim addresses at slots.
  logic [31:0] slot_hi   [TLB_ENTRIES_DEF];
  logic [31:0] slot_mask [TLB_ENTRIES_DEF];
  bit          slot_used [TLB_ENTRIES_DEF];
  logic [7:0]  cur_asid = 8'd0;
  int          burst_left = 0;
  int          rx_mode = 0, rx_span = 0, rx_cnt = 0;

  mips_tlb_address_translate #(.TLB_ENTRIES(TLB_ENTRIES_DEF)) dut (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  mips_tlb_translate_checker xlat_check (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_we, .cfg_index, .cfg_data, .errors, .outstanding, .n_writes, .n_ok,
    .n_refill, .n_invalid, .n_modified
  );

  always #(CLK_HALF) clk = ~clk;

  // Receiver: switch between always ready, coin flip, a fixed duty pattern
  // and long stalls, each for a random stretch of cycles.
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(50, 300);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (rx_cnt % 5) < 2;
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
    rx_cnt++;
  end

  function automatic logic [31:0] lo_word(input logic [23:0] pfn, input logic d,
                                          input logic v, input logic g);
    return {2'b00, pfn, 3'b000, d, v, g};
  endfunction

  // Translate command; the unused fields carry random noise.
  function automatic in_item_t xlat(input logic [31:0] va, input logic st);
    in_item_t it;
    it.cmd           = CMD_XLAT;
    it.vaddr         = va;
    it.is_store      = st;
    it.entry_index   = IDX_FIELD_W'($urandom_range(0, 63));
    it.page_mask     = $urandom;
    it.entry_hi      = $urandom;
    it.entry_lo_even = $urandom;
    it.entry_lo_odd  = $urandom;
    return it;
  endfunction

  function automatic in_item_t wr(input logic [5:0] idx, input logic [31:0] mask,
                                  input logic [31:0] hi, input logic [31:0] lo0,
                                  input logic [31:0] lo1);
    in_item_t it;
    it.cmd           = CMD_WRITE;
    it.vaddr         = $urandom;
    it.is_store      = 1'($urandom_range(0, 1));
    it.entry_index   = idx;
    it.page_mask     = mask;
    it.entry_hi      = hi;
    it.entry_lo_even = lo0;
    it.entry_lo_odd  = lo1;
    return it;
  endfunction

  // Hold the item until the transfer, then either go straight on with the
  // burst or drop valid for a random gap.
  task automatic send(input in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.cmd == CMD_WRITE) begin
      slot_hi[it.entry_index]   = it.entry_hi;
      slot_mask[it.entry_index] = it.page_mask;
      slot_used[it.entry_index] = 1'b1;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] asid, input logic erl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RUN_ASID;
    cfg_data  <= CFG_DATA_W'(asid);
    @(posedge clk);
    cfg_index <= CFG_ERROR_LEVEL;
    cfg_data  <= CFG_DATA_W'(erl);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_asid  = asid;
  endtask

  // Mostly well-formed traffic: slot loads with realistic page masks, and
  // addresses aimed inside loaded pages; the rest hits kseg0/1 or is random.
  task automatic run_random(input int count);
    in_item_t    it;
    int          k, pick;
    logic [31:0] span;
    repeat (count) begin
      it = xlat($urandom, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) begin
        it.cmd = CMD_WRITE;
        if ($urandom_range(0, 3) != 0) it.entry_index = IDX_FIELD_W'($urandom_range(0, 11));
        k = $urandom_range(0, 9);
        // Odd masks land in the high slots so they do not shadow everything.
        if (k <= 8) it.page_mask = ((32'd1 << (2 * k)) - 32'd1) << 13;
        else it.entry_index = IDX_FIELD_W'($urandom_range(32, 63));
        if ($urandom_range(0, 1)) it.entry_hi[31:30] = 2'b11;
        if ($urandom_range(0, 4) != 0) it.entry_hi[7:0] = cur_asid;
        it.entry_lo_even[1] = ($urandom_range(0, 7) != 0);
        it.entry_lo_odd[1]  = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 3) == 0) begin
          it.entry_lo_even[0] = 1'b1;
          it.entry_lo_odd[0]  = 1'b1;
        end
      end else begin
        k = $urandom_range(0, 9);
        if (k < 6) begin
          pick = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : $urandom_range(0, 63);
          if (slot_used[pick]) begin
            span     = slot_mask[pick] | PAGE_MIN_SPAN;
            it.vaddr = (slot_hi[pick] & ~span) | (it.vaddr & span);
          end
        end else if (k < 8) begin
          it.vaddr = KSEG0_BASE | (it.vaddr & KSEG01_SPAN);
        end
      end
      send(it);
    end
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: kuseg identity, kseg0/1 unmapped, kseg2/3 miss an empty store.
    send(xlat(32'h0000_0000, 1'b0));
    send(xlat(32'h7FFF_FFFF, 1'b1));
    send(xlat(32'h8000_0000, 1'b0));
    send(xlat(32'hBFFF_FFFF, 1'b1));
    send(xlat(32'hC000_0000, 1'b0));
    send(xlat(32'hFFFF_FFFF, 1'b1));

    wait_idle();
    set_config(8'h11, 1'b0);
    // Zeroed slots carry ASID 0 and no G bits, so they miss under ASID 0x11.
    send(xlat(32'h0000_1000, 1'b0));
    // 4 KB page pair: even hit, store to a clean odd page, odd hit.
    send(wr(6'd3, 32'h0, 32'h0000_4011, lo_word(24'h012345, 1'b1, 1'b1, 1'b0),
            lo_word(24'h0ABCDE, 1'b0, 1'b1, 1'b0)));
    send(xlat(32'h0000_4ABC, 1'b0));
    send(xlat(32'h0000_5ABC, 1'b1));
    send(xlat(32'h0000_5ABC, 1'b0));
    // Global 256 MB pair under a foreign ASID; the odd half is not valid.
    send(wr(6'd5, 32'h1FFF_E000, 32'hC000_0022, lo_word(24'hFFFFFF, 1'b1, 1'b1, 1'b1),
            lo_word(24'h000001, 1'b1, 1'b0, 1'b1)));
    send(xlat(32'hC123_4567, 1'b1));
    send(xlat(32'hD000_0000, 1'b0));
    // Same page in a lower slot wins even though it is invalid.
    send(wr(6'd1, 32'h0, 32'h0000_4011, 32'h0, 32'h0));
    send(xlat(32'h0000_4000, 1'b0));
    // A single G bit does not make the entry global.
    send(wr(6'd6, 32'h0, 32'h0000_8033, lo_word(24'h000123, 1'b0, 1'b1, 1'b1),
            lo_word(24'h000456, 1'b0, 1'b1, 1'b0)));
    send(xlat(32'h0000_8000, 1'b0));
    // All-ones mask in the last slot: catches everything, select bit zero,
    // so the address is its own offset.
    send(wr(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(xlat(32'h1234_5678, 1'b1));
    send(wr(6'd63, 32'h0, 32'hFFFF_E0AA, 32'h0, 32'h0));
    // 16 KB page pair in slot zero.
    send(wr(6'd0, 32'h0000_6000, 32'h7FFF_E011, lo_word(24'hF0F0F0, 1'b1, 1'b1, 1'b0),
            lo_word(24'h0F0F0F, 1'b1, 1'b1, 1'b0)));
    send(xlat(32'h7FFF_F123, 1'b1));

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      case (p)
        0:       set_config(8'h00, 1'b0);
        1:       set_config(8'hFF, 1'b0);
        2:       set_config(8'($urandom_range(1, 254)), 1'b1);
        3:       set_config(8'($urandom_range(0, 255)), 1'b0);
        4:       set_config(8'hFF, 1'b1);
        default: set_config(8'h00, 1'b0);
      endcase
      run_random(RANDOM_ITEMS / N_PHASES);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d slot writes and %0d translations over %0d config settings",
             n_writes, n_ok + n_refill + n_invalid + n_modified, N_PHASES + 2);
    $display("summary: translations ok %0d, refill %0d, invalid %0d, modified %0d",
             n_ok, n_refill, n_invalid, n_modified);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/mtlb_pkg.sv
hw/rtl/mtlb_mem.sv
hw/rtl/mtlb_ctrl.sv
hw/rtl/mips_tlb_address_translate.sv
verif/mips_tlb_translate_checker.sv
verif/mips_tlb_address_translate_tb.sv
